// File: src/rvx_pkg.sv
`timescale 1ns / 1ps
package rvx_pkg;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_LUI    = 7'h37;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_B    = 3'd0;
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_BU   = 3'd4;
    localparam logic [2:0] F3_HU   = 3'd5;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [31:0] CALL_INT  = 32'd1;
    localparam logic [31:0] CALL_STR  = 32'd4;
    localparam logic [31:0] CALL_EXIT = 32'd10;
    localparam logic [31:0] CALL_CHAR = 32'd11;

    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A1 = 5'd11;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_EXIT    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_BADCALL = 2'd3;

    localparam logic [1:0] CON_NONE = 2'd0;
    localparam logic [1:0] CON_INT  = 2'd1;
    localparam logic [1:0] CON_CHAR = 2'd2;
    localparam logic [1:0] CON_STR  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MDWAIT,
        S_AWAIT,
        S_LDADR,
        S_LDCAP,
        S_STORE,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        CLS_DONE,
        CLS_MD,
        CLS_LOAD,
        CLS_STORE
    } t_cls;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_MULH,
        MD_DIV,
        MD_REM
    } t_mdop;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_md_rsp;

endpackage

// File: src/rvx_muldiv.sv
`timescale 1ns / 1ps
module rvx_muldiv
    import rvx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic        r_is_div;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic [31:0] r_b;

    logic [32:0] sum;
    logic [32:0] shifted;
    logic [33:0] diff;

    // shift-add for multiply, restoring subtract for divide
    always_comb begin
        sum     = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_b} : 33'd0);
        shifted = {r_hi, r_lo[31]};
        diff    = {1'b0, shifted} - {2'b00, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_hi     <= '0;
            r_lo     <= i_req.a;
            r_b      <= i_req.b;
            r_is_div <= i_req.is_div;
        end else if (r_busy) begin
            if (r_is_div) begin
                if (!diff[33]) begin
                    r_hi <= diff[31:0];
                    r_lo <= {r_lo[30:0], 1'b1};
                end else begin
                    r_hi <= shifted[31:0];
                    r_lo <= {r_lo[30:0], 1'b0};
                end
            end else begin
                r_hi <= sum[32:1];
                r_lo <= {sum[0], r_lo[31:1]};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

endmodule

// File: src/rv32im_subset_execute.sv
`timescale 1ns / 1ps
// Executes one RV32 instruction word per transaction against an internal register
// file, program counter and byte data memory; one instruction is in flight at a time.
// After reset a clearing pass writes zero to all MEM_BYTES memory bytes, one per
// cycle, before the first instruction is taken. Mul, mulh, div and rem (div and rem
// by zero excepted) run through the 32 steps of the shared radix-2 multiply/divide
// unit. For loads and stores the address is first folded into memory range, then
// bytes move one per cycle (stores) or through an address and a capture state each
// (loads) through the byte-wide memory. A stalled result holds the block; the next
// transaction can be taken in the cycle after the result register loads. After a
// halting instruction every further transaction repeats the halt status.
module rv32im_subset_execute
    import rvx_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_rd_written,
    output logic [4:0]  o_rd_index,
    output logic [31:0] o_rd_value,
    output logic [1:0]  o_status,
    output logic [1:0]  o_console_kind,
    output logic [31:0] o_console_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
    localparam logic [AW:0]   MEM_SIZE  = (AW+1)'(MEM_BYTES);
    // 2^AW mod MEM_BYTES, used to fold the upper address bits down
    localparam logic [AW-1:0] WRAP_REM  = AW'((1 << AW) - MEM_BYTES);

    t_state r_state, n_state;

    logic [31:0] r_start_pc;
    logic [31:0] r_pc;
    logic        r_halted;
    logic [1:0]  r_halt_code;
    logic [31:0] r_instr;

    logic [31:0] r_rf [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_rd1_q, r_rd2_q;
    logic        r_rd1_vld, r_rd2_vld;

    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_mem_q;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_maddr;
    logic [1:0]    r_bcnt;
    logic [32:0]   r_wa;

    logic [31:0] r_val;
    logic        r_wr;
    logic [31:0] r_npc;
    logic [1:0]  r_status;
    logic [1:0]  r_ckind;
    logic [31:0] r_cval;
    logic [1:0]  r_nb;
    logic        r_lsgn;
    t_mdop       r_mdop;
    logic        r_sa, r_neg;
    logic [31:0] r_stdata;

    logic        r_o_valid;
    logic [31:0] r_o_npc;
    logic        r_o_wr;
    logic [4:0]  r_o_rd;
    logic [31:0] r_o_val;
    logic [1:0]  r_o_status;
    logic [1:0]  r_o_ckind;
    logic [31:0] r_o_cval;

    logic          acc, cfg_wr, out_free, rd_en;
    logic [4:0]    ra1, ra2;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] maddr_inc;
    logic [32:0]   wa_fold;
    t_md_req       md_req;
    t_md_rsp       md_rsp;

    logic [31:0] a, b, w, imm_i, imm_s, imm_b, imm_j;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd, shamt;
    t_cls        d_cls;
    t_mdop       d_mdop;
    logic [31:0] d_val, d_npc, d_addr, d_cval;
    logic        d_wr, d_bad, d_lsgn;
    logic [1:0]  d_status, d_ckind, d_nb;
    logic [63:0] prod;
    logic [31:0] md_val, ld_next;

    rvx_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign acc      = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? r_start_pc : 32'd0;
    assign maddr_inc = (r_maddr == LAST_ADDR) ? '0 : r_maddr + AW'(1);
    assign wa_fold  = 33'(r_wa[32:AW]) * 33'(WRAP_REM) + 33'(r_wa[AW-1:0]);

    // decode and combinational execute
    always_comb begin
        w      = r_instr;
        op     = w[6:0];
        rd     = w[11:7];
        f3     = w[14:12];
        shamt  = w[24:20];
        f7     = w[31:25];
        a      = r_rd1_vld ? r_rd1_q : 32'd0;
        b      = r_rd2_vld ? r_rd2_q : 32'd0;
        imm_i  = {{20{w[31]}}, w[31:20]};
        imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d_cls    = CLS_DONE;
        d_mdop   = MD_MUL;
        d_val    = 32'd0;
        d_wr     = 1'b0;
        d_bad    = 1'b0;
        d_status = ST_RUN;
        d_npc    = r_pc + 32'd4;
        d_ckind  = CON_NONE;
        d_cval   = 32'd0;
        d_nb     = 2'd0;
        d_lsgn   = 1'b0;
        d_addr   = a + imm_i;
        case (op)
            OP_REG: begin
                d_wr = 1'b1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD: d_val = a + b;
                        F3_SLL: d_val = a << b[4:0];
                        F3_SLT: d_val = {31'd0, $signed(a) < $signed(b)};
                        F3_XOR: d_val = a ^ b;
                        F3_SR:  d_val = a >> b[4:0];
                        F3_OR:  d_val = a | b;
                        F3_AND: d_val = a & b;
                        default: d_bad = 1'b1;
                    endcase
                end else if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_MUL: begin
                            d_cls  = CLS_MD;
                            d_mdop = MD_MUL;
                        end
                        F3_MULH: begin
                            d_cls  = CLS_MD;
                            d_mdop = MD_MULH;
                        end
                        F3_DIV: begin
                            if (b == 32'd0) begin
                                d_val = 32'hFFFF_FFFF;
                            end else begin
                                d_cls  = CLS_MD;
                                d_mdop = MD_DIV;
                            end
                        end
                        F3_REM: begin
                            if (b == 32'd0) begin
                                d_val = a;
                            end else begin
                                d_cls  = CLS_MD;
                                d_mdop = MD_REM;
                            end
                        end
                        default: d_bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) begin
                        d_val = a - b;
                    end else if (f3 == F3_SR) begin
                        d_val = $signed(a) >>> b[4:0];
                    end else begin
                        d_bad = 1'b1;
                    end
                end else begin
                    d_bad = 1'b1;
                end
            end
            OP_IMM: begin
                d_wr = 1'b1;
                case (f3)
                    F3_ADD: d_val = a + imm_i;
                    F3_SLL: begin
                        if (f7 == F7_BASE) d_val = a << shamt;
                        else d_bad = 1'b1;
                    end
                    F3_SLT: d_val = {31'd0, $signed(a) < $signed(imm_i)};
                    F3_XOR: d_val = a ^ imm_i;
                    F3_SR: begin
                        if (f7 == F7_BASE) d_val = a >> shamt;
                        else if (f7 == F7_ALT) d_val = $signed(a) >>> shamt;
                        else d_bad = 1'b1;
                    end
                    F3_OR:  d_val = a | imm_i;
                    F3_AND: d_val = a & imm_i;
                    default: d_bad = 1'b1;
                endcase
            end
            OP_LOAD: begin
                d_wr  = 1'b1;
                d_cls = CLS_LOAD;
                case (f3)
                    F3_B: d_lsgn = 1'b1;
                    F3_H: begin
                        d_nb   = 2'd1;
                        d_lsgn = 1'b1;
                    end
                    F3_W:  d_nb = 2'd3;
                    F3_BU: d_nb = 2'd0;
                    F3_HU: d_nb = 2'd1;
                    default: d_bad = 1'b1;
                endcase
            end
            OP_STORE: begin
                d_addr = a + imm_s;
                d_cls  = CLS_STORE;
                case (f3)
                    F3_B: d_nb = 2'd0;
                    F3_H: d_nb = 2'd1;
                    F3_W: d_nb = 2'd3;
                    default: d_bad = 1'b1;
                endcase
            end
            OP_BRANCH: begin
                case (f3)
                    F3_BEQ: if (a == b) d_npc = r_pc + imm_b;
                    F3_BNE: if (a != b) d_npc = r_pc + imm_b;
                    default: d_bad = 1'b1;
                endcase
            end
            OP_JAL: begin
                d_wr  = 1'b1;
                d_val = r_pc + 32'd4;
                d_npc = r_pc + imm_j;
            end
            OP_LUI: begin
                d_wr  = 1'b1;
                d_val = {w[31:12], 12'd0};
            end
            OP_SYSTEM: begin
                // a0 and a1 were read into the rs1/rs2 slots
                case (a)
                    CALL_INT: begin
                        d_ckind = CON_INT;
                        d_cval  = b;
                    end
                    CALL_STR: begin
                        d_ckind = CON_STR;
                        d_cval  = b;
                    end
                    CALL_CHAR: begin
                        d_ckind = CON_CHAR;
                        d_cval  = b;
                    end
                    CALL_EXIT: d_status = ST_EXIT;
                    default:   d_status = ST_BADCALL;
                endcase
            end
            default: d_bad = 1'b1;
        endcase
        if (d_bad) d_status = ST_ILLEGAL;
        if (d_status != ST_RUN) begin
            d_wr  = 1'b0;
            d_val = 32'd0;
            d_npc = r_pc;
            d_cls = CLS_DONE;
        end
    end

    always_comb begin
        prod = {md_rsp.hi, md_rsp.lo};
        if (r_neg) prod = -prod;
        case (r_mdop)
            MD_MUL:  md_val = prod[31:0];
            MD_MULH: md_val = prod[63:32];
            MD_DIV:  md_val = r_neg ? -md_rsp.lo : md_rsp.lo;
            MD_REM:  md_val = r_sa ? -md_rsp.hi : md_rsp.hi;
            default: md_val = 32'd0;
        endcase
        ld_next = r_val;
        ld_next[{r_bcnt, 3'b000} +: 8] = r_mem_q;
        if (r_lsgn && r_nb == 2'd0) ld_next = {{24{ld_next[7]}}, ld_next[7:0]};
        if (r_lsgn && r_nb == 2'd1) ld_next = {{16{ld_next[15]}}, ld_next[15:0]};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: begin
                if (acc) n_state = r_halted ? S_FINISH : S_EXEC;
            end
            S_EXEC: begin
                case (d_cls)
                    CLS_MD:    n_state = S_MDWAIT;
                    CLS_LOAD:  n_state = S_AWAIT;
                    CLS_STORE: n_state = S_AWAIT;
                    default:   n_state = S_FINISH;
                endcase
            end
            S_MDWAIT: if (md_rsp.done) n_state = S_FINISH;
            S_AWAIT: begin
                if (r_wa[32:AW] == '0) n_state = (r_wr) ? S_LDADR : S_STORE;
            end
            S_LDADR: n_state = S_LDCAP;
            S_LDCAP: n_state = (r_bcnt == r_nb) ? S_FINISH : S_LDADR;
            S_STORE: if (r_bcnt == r_nb) n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall = (r_state != S_IDLE);
        rd_en   = (r_state == S_IDLE) && acc;
        ra1     = i_instr_word[19:15];
        ra2     = i_instr_word[24:20];
        if (i_instr_word[6:0] == OP_SYSTEM) begin
            ra1 = REG_A0;
            ra2 = REG_A1;
        end
        md_req.start  = 1'b0;
        md_req.is_div = 1'b0;
        md_req.a      = 32'd0;
        md_req.b      = 32'd0;
        if (r_state == S_EXEC && d_cls == CLS_MD) begin
            md_req.start  = 1'b1;
            md_req.is_div = (d_mdop == MD_DIV) || (d_mdop == MD_REM);
            md_req.a      = a[31] ? -a : a;
            md_req.b      = b[31] ? -b : b;
        end
        mem_we = 1'b0;
        mem_wa = r_maddr;
        mem_wd = r_stdata[{r_bcnt, 3'b000} +: 8];
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = 8'd0;
        end else if (r_state == S_STORE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_mem_q <= r_mem[r_maddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free && r_wr && rd != 5'd0) begin
            r_rf[rd] <= r_val;
        end
        if (rd_en) begin
            r_rd1_q <= r_rf[ra1];
            r_rd2_q <= r_rf[ra2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_start_pc  <= 32'd0;
            r_pc        <= 32'd0;
            r_halted    <= 1'b0;
            r_halt_code <= ST_RUN;
            r_rf_vld    <= 32'd0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (r_state == S_FINISH && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_FINISH && out_free) begin
                r_pc      <= r_npc;
                if (r_status != ST_RUN) begin
                    r_halted    <= 1'b1;
                    r_halt_code <= r_status;
                end
                if (r_wr && rd != 5'd0) r_rf_vld[rd] <= 1'b1;
            end
            if (cfg_wr) begin
                r_start_pc <= pwdata;
                r_pc       <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd1_vld <= r_rf_vld[ra1];
            r_rd2_vld <= r_rf_vld[ra2];
        end
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    r_instr  <= i_instr_word;
                    r_wr     <= 1'b0;
                    r_val    <= 32'd0;
                    r_npc    <= r_pc;
                    r_status <= r_halt_code;
                    r_ckind  <= CON_NONE;
                    r_cval   <= 32'd0;
                end
            end
            S_EXEC: begin
                r_val    <= d_val;
                r_wr     <= d_wr;
                r_npc    <= d_npc;
                r_status <= d_status;
                r_ckind  <= d_ckind;
                r_cval   <= d_cval;
                r_nb     <= d_nb;
                r_lsgn   <= d_lsgn;
                r_mdop   <= d_mdop;
                r_sa     <= a[31];
                r_neg    <= a[31] ^ b[31];
                r_stdata <= b;
                r_wa     <= {1'b0, d_addr};
            end
            S_MDWAIT: if (md_rsp.done) r_val <= md_val;
            S_AWAIT: begin
                if (r_wa[32:AW] == '0) begin
                    r_maddr <= ({1'b0, r_wa[AW-1:0]} >= MEM_SIZE) ?
                               r_wa[AW-1:0] + WRAP_REM : r_wa[AW-1:0];
                    r_bcnt  <= 2'd0;
                    r_val   <= 32'd0;
                end else begin
                    r_wa <= wa_fold;
                end
            end
            S_LDCAP: begin
                r_val   <= ld_next;
                r_maddr <= maddr_inc;
                r_bcnt  <= r_bcnt + 2'd1;
            end
            S_STORE: begin
                r_maddr <= maddr_inc;
                r_bcnt  <= r_bcnt + 2'd1;
            end
            default: ;
        endcase
        if (r_state == S_FINISH && out_free) begin
            r_o_npc    <= r_npc;
            r_o_wr     <= r_wr && (rd != 5'd0);
            r_o_rd     <= (r_wr && rd != 5'd0) ? rd : 5'd0;
            r_o_val    <= (r_wr && rd != 5'd0) ? r_val : 32'd0;
            r_o_status <= r_status;
            r_o_ckind  <= r_ckind;
            r_o_cval   <= r_cval;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_next_pc       = r_o_npc;
    assign o_rd_written    = r_o_wr;
    assign o_rd_index      = r_o_rd;
    assign o_rd_value      = r_o_val;
    assign o_status        = r_o_status;
    assign o_console_kind  = r_o_ckind;
    assign o_console_value = r_o_cval;

    a_wr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rd_written |-> o_rd_index != 5'd0)
        else $error("register write reported for x0");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_RUN |-> !o_rd_written && o_console_kind == CON_NONE)
        else $error("halting transaction has side effects");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !md_rsp.busy)
        else $error("shared unit busy while idle");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && !cfg_wr |=> r_halted && $stable(r_pc))
        else $error("state changed after halt");

endmodule

// File: tb/sv/rv32im_subset_execute_test.sv
`timescale 1ns / 1ps
module rv32im_subset_execute_test;
    import rvx_pkg::*;

    localparam logic [2:0] ADDR_START_PC = 3'd0;
    localparam logic [2:0] F3_UNUSED = 3'd3;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        rd_written;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic [1:0]  status;
        logic [1:0]  console_kind;
        logic [31:0] console_value;
    } t_exec_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instr_word;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_next_pc;
    logic        o_rd_written;
    logic [4:0]  o_rd_index;
    logic [31:0] o_rd_value;
    logic [1:0]  o_status;
    logic [1:0]  o_console_kind;
    logic [31:0] o_console_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rv32im_subset_execute dut (.*);

    // architectural copy
    logic [31:0] arch_regs [32];
    logic [31:0] arch_pc;
    logic [31:0] arch_start_pc;
    bit   [7:0]  arch_mem [bit [15:0]];
    logic        arch_halted;
    logic [1:0]  arch_halt_code;

    t_exec_result pending_results [$];
    int  error_count;
    int  quiet_cycles;
    bit  tx_idle_on;
    bit  rx_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] r_word(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                            logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] i_word(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                            logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] s_word(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                            logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] b_word(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                            logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] j_word(logic [20:0] off, logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
    endfunction

    function automatic logic [31:0] mem_load(logic [31:0] addr, int nbytes);
        logic [31:0] v;
        logic [15:0] a;
        v = '0;
        for (int i = nbytes - 1; i >= 0; i--) begin
            a = 16'(addr + 32'(i));
            v = {v[23:0], arch_mem.exists(a) ? arch_mem[a] : 8'h00};
        end
        return v;
    endfunction

    function automatic void mem_store(logic [31:0] addr, int nbytes, logic [31:0] v);
        for (int i = 0; i < nbytes; i++)
            arch_mem[16'(addr + 32'(i))] = v[8*i +: 8];
    endfunction

    function automatic t_exec_result execute_instr(logic [31:0] w);
        t_exec_result r;
        logic [6:0]  op, f7;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [31:0] a, b, imm, pc, npc, val, addr;
        logic [1:0]  st, ck;
        logic [31:0] cv;
        logic        wr, bad;
        longint      sa, sb, prod;
        op = w[6:0]; rd = w[11:7]; f3 = w[14:12];
        rs1 = w[19:15]; rs2 = w[24:20]; f7 = w[31:25];
        a = arch_regs[rs1]; b = arch_regs[rs2];
        imm = {{20{w[31]}}, w[31:20]};
        pc = arch_pc; npc = pc + 32'd4;
        val = '0; st = ST_RUN; ck = CON_NONE; cv = '0; wr = 1'b0; bad = 1'b0;
        sa = longint'(signed'(a)); sb = longint'(signed'(b));
        if (arch_halted) begin
            r = '{pc, 1'b0, 5'd0, 32'd0, arch_halt_code, CON_NONE, 32'd0};
            return r;
        end
        case (op)
            OP_REG: begin
                wr = 1'b1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD: val = a + b;
                        F3_SLL: val = a << b[4:0];
                        F3_SLT: val = {31'd0, signed'(a) < signed'(b)};
                        F3_XOR: val = a ^ b;
                        F3_SR:  val = a >> b[4:0];
                        F3_OR:  val = a | b;
                        F3_AND: val = a & b;
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_MUL:  val = a * b;
                        F3_MULH: begin
                            prod = sa * sb;
                            val = prod[63:32];
                        end
                        F3_DIV:  val = (b == 0) ? 32'hFFFF_FFFF : 32'(sa / sb);
                        F3_REM:  val = (b == 0) ? a : 32'(sa % sb);
                        default: bad = 1'b1;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) val = a - b;
                    else if (f3 == F3_SR) val = signed'(a) >>> b[4:0];
                    else bad = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OP_IMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD: val = a + imm;
                    F3_SLL: if (f7 == F7_BASE) val = a << rs2; else bad = 1'b1;
                    F3_SLT: val = {31'd0, signed'(a) < signed'(imm)};
                    F3_XOR: val = a ^ imm;
                    F3_SR: begin
                        if (f7 == F7_BASE) val = a >> rs2;
                        else if (f7 == F7_ALT) val = signed'(a) >>> rs2;
                        else bad = 1'b1;
                    end
                    F3_OR:  val = a | imm;
                    F3_AND: val = a & imm;
                    default: bad = 1'b1;
                endcase
            end
            OP_LOAD: begin
                wr = 1'b1;
                addr = a + imm;
                case (f3)
                    F3_B: begin
                        val = mem_load(addr, 1);
                        val = {{24{val[7]}}, val[7:0]};
                    end
                    F3_H: begin
                        val = mem_load(addr, 2);
                        val = {{16{val[15]}}, val[15:0]};
                    end
                    F3_W:  val = mem_load(addr, 4);
                    F3_BU: val = mem_load(addr, 1);
                    F3_HU: val = mem_load(addr, 2);
                    default: bad = 1'b1;
                endcase
            end
            OP_STORE: begin
                addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
                if (f3 == F3_B) mem_store(addr, 1, b);
                else if (f3 == F3_H) mem_store(addr, 2, b);
                else if (f3 == F3_W) mem_store(addr, 4, b);
                else bad = 1'b1;
            end
            OP_BRANCH: begin
                imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                if (f3 == F3_BEQ) begin
                    if (a == b) npc = pc + imm;
                end else if (f3 == F3_BNE) begin
                    if (a != b) npc = pc + imm;
                end else begin
                    bad = 1'b1;
                end
            end
            OP_JAL: begin
                wr = 1'b1;
                val = pc + 32'd4;
                npc = pc + {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
            end
            OP_LUI: begin
                wr = 1'b1;
                val = {w[31:12], 12'h000};
            end
            OP_SYSTEM: begin
                case (arch_regs[REG_A0])
                    CALL_INT:  begin ck = CON_INT;  cv = arch_regs[REG_A1]; end
                    CALL_STR:  begin ck = CON_STR;  cv = arch_regs[REG_A1]; end
                    CALL_CHAR: begin ck = CON_CHAR; cv = arch_regs[REG_A1]; end
                    CALL_EXIT: st = ST_EXIT;
                    default:   st = ST_BADCALL;
                endcase
            end
            default: bad = 1'b1;
        endcase
        if (bad) st = ST_ILLEGAL;
        if (st != ST_RUN) begin
            wr = 1'b0; val = '0; npc = pc;
            arch_halted = 1'b1; arch_halt_code = st;
        end
        if (!wr || rd == 0) begin
            wr = 1'b0; val = '0; rd = '0;
        end else begin
            arch_regs[rd] = val;
        end
        arch_pc = npc;
        r = '{npc, wr, rd, val, st, ck, cv};
        return r;
    endfunction

    task automatic send_instr(logic [31:0] w);
        while (tx_idle_on && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_instr_word <= w;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(execute_instr(w));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_pc(logic [31:0] value);
        wait_drained();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_START_PC; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        arch_start_pc = value;
        arch_pc = value;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_reg(logic [4:0] rd, logic [31:0] value);
        send_instr({value[31:12] + 20'(value[11]), rd, OP_LUI});
        send_instr(i_word(value[11:0], rd, F3_ADD, rd, OP_IMM));
    endtask

    task automatic test_alu_and_muldiv();
        set_reg(5'd1, 32'h8000_0000);
        send_instr(i_word(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM));
        send_instr(r_word(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OP_REG));
        send_instr(r_word(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd4, OP_REG));
        send_instr(r_word(F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd5, OP_REG));
        send_instr(r_word(F7_MULDIV, 5'd0, 5'd2, F3_REM, 5'd6, OP_REG));
        send_instr(r_word(F7_MULDIV, 5'd1, 5'd1, F3_MULH, 5'd7, OP_REG));
        send_instr(r_word(F7_MULDIV, 5'd2, 5'd1, F3_MUL, 5'd0, OP_REG));
        send_instr(r_word(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd8, OP_REG));
        send_instr(i_word({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd9, OP_IMM));
        send_instr(r_word(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd10, OP_REG));
        send_instr(i_word(12'h7FF, 5'd2, F3_SLT, 5'd11, OP_IMM));
    endtask

    task automatic test_memory_wrap();
        // word store straddling the top of memory
        send_instr(s_word(12'h000, 5'd1, 5'd2, F3_W));
        send_instr(i_word(12'h000, 5'd2, F3_W, 5'd12, OP_LOAD));
        send_instr(i_word(12'h001, 5'd2, F3_B, 5'd13, OP_LOAD));
        send_instr(i_word(12'h800, 5'd1, F3_HU, 5'd14, OP_LOAD));
        send_instr(s_word(12'h7FF, 5'd2, 5'd0, F3_H));
        send_instr(i_word(12'h7FF, 5'd0, F3_H, 5'd15, OP_LOAD));
        send_instr(s_word(12'h003, 5'd2, 5'd0, F3_B));
        send_instr(i_word(12'h003, 5'd0, F3_BU, 5'd16, OP_LOAD));
    endtask

    task automatic test_branches_and_console();
        write_start_pc(32'hFFFF_FFF8);
        send_instr(b_word(13'h0010, 5'd0, 5'd0, F3_BEQ));
        send_instr(b_word(13'h1000, 5'd1, 5'd2, F3_BNE));
        send_instr(j_word(21'h1F_FFFC, 5'd1));
        send_instr(j_word(21'h0F_FFFE, 5'd0));
        send_instr({20'hFFFFF, 5'd17, OP_LUI});
        send_instr(i_word(CALL_INT[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
        send_instr(32'h0000_0073);
        send_instr(i_word(CALL_CHAR[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
        send_instr(32'hFFFF_FFF3);
        send_instr(i_word(CALL_STR[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
        send_instr(32'h0000_0073);
        write_start_pc(32'hFFFF_FFFF);
        send_instr(j_word(21'h00_0004, 5'd3));
    endtask

    function automatic logic [31:0] random_instr();
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] w;
        int          pick;
        rd = 5'($urandom); rs2 = 5'($urandom);
        rs1 = ($urandom_range(99) < 60) ? 5'($urandom_range(1, 4)) : 5'($urandom);
        pick = $urandom_range(99);
        if (pick < 28) begin
            case ($urandom_range(2))
                0: begin
                    f7 = F7_BASE;
                    f3 = 3'($urandom_range(6));
                    if (f3 == F3_UNUSED) f3 = F3_AND;
                end
                1: begin
                    f7 = F7_ALT;
                    f3 = $urandom_range(1) ? F3_SR : F3_ADD;
                end
                default: begin
                    f7 = F7_MULDIV;
                    case ($urandom_range(3))
                        0: f3 = F3_MUL;
                        1: f3 = F3_MULH;
                        2: f3 = F3_DIV;
                        default: f3 = F3_REM;
                    endcase
                    if ($urandom_range(9) == 0) rs2 = 5'd0;
                end
            endcase
            w = r_word(f7, rs2, rs1, f3, rd, OP_REG);
        end else if (pick < 50) begin
            w = i_word(12'($urandom), 5'($urandom), 3'($urandom), rd, OP_IMM);
            if (w[14:12] == F3_UNUSED) w[14:12] = F3_ADD;
            if (w[14:12] == F3_SLL) w[31:25] = F7_BASE;
            if (w[14:12] == F3_SR) w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
        end else if (pick < 64) begin
            case ($urandom_range(4))
                0: f3 = F3_B;
                1: f3 = F3_H;
                2: f3 = F3_W;
                3: f3 = F3_BU;
                default: f3 = F3_HU;
            endcase
            w = i_word(12'($urandom), rs1, f3, rd, OP_LOAD);
        end else if (pick < 78) begin
            f3 = 3'($urandom_range(2));
            w = s_word(12'($urandom), rs2, rs1, f3);
        end else if (pick < 86) begin
            w = b_word(13'($urandom), rs2, 5'($urandom_range(0, 4)),
                       $urandom_range(1) ? F3_BNE : F3_BEQ);
        end else if (pick < 91) begin
            w = j_word(21'($urandom), rd);
        end else begin
            w = {20'($urandom), rd, OP_LUI};
        end
        return w;
    endfunction

    task automatic test_random(int count);
        logic [31:0] call;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 4) begin
                case ($urandom_range(2))
                    0: call = CALL_INT;
                    1: call = CALL_CHAR;
                    default: call = CALL_STR;
                endcase
                send_instr(i_word(call[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
                send_instr({25'($urandom), OP_SYSTEM});
            end else begin
                send_instr(random_instr());
            end
        end
    endtask

    task automatic test_halt();
        case ($urandom_range(2))
            0: send_instr(i_word(CALL_EXIT[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
            1: send_instr(i_word(12'h7FF, 5'd0, F3_ADD, REG_A0, OP_IMM));
            default: send_instr(r_word(F7_BASE, 5'd1, 5'd2, F3_UNUSED, 5'd4, OP_REG));
        endcase
        send_instr(32'h0000_0073);
        for (int n = 0; n < 6; n++) send_instr(random_instr());
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= rx_idle_on && ($urandom_range(99) < 16);
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expectation, next_pc %h", o_next_pc);
                    error_count++;
                end else begin
                    t_exec_result e;
                    e = pending_results.pop_front();
                    if (o_next_pc !== e.next_pc) begin
                        $error("next_pc exp %h got %h", e.next_pc, o_next_pc); error_count++;
                    end
                    if (o_rd_written !== e.rd_written) begin
                        $error("rd_written exp %h got %h", e.rd_written, o_rd_written);
                        error_count++;
                    end
                    if (o_rd_index !== e.rd_index) begin
                        $error("rd_index exp %h got %h", e.rd_index, o_rd_index); error_count++;
                    end
                    if (o_rd_value !== e.rd_value) begin
                        $error("rd_value exp %h got %h", e.rd_value, o_rd_value); error_count++;
                    end
                    if (o_status !== e.status) begin
                        $error("status exp %h got %h", e.status, o_status); error_count++;
                    end
                    if (o_console_kind !== e.console_kind) begin
                        $error("console_kind exp %h got %h", e.console_kind, o_console_kind);
                        error_count++;
                    end
                    if (o_console_value !== e.console_value) begin
                        $error("console_value exp %h got %h", e.console_value, o_console_value);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_instr_word <= '0; i_stall <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        error_count = 0; quiet_cycles = 0; tx_idle_on = 1'b1; rx_idle_on = 1'b1;
        for (int i = 0; i < 32; i++) arch_regs[i] = '0;
        arch_start_pc = '0; arch_pc = '0; arch_halted = 1'b0; arch_halt_code = ST_RUN;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_start_pc(32'h0000_0000);
        test_alu_and_muldiv();
        test_memory_wrap();
        test_branches_and_console();
        write_start_pc(32'($urandom));
        test_random(400);
        write_start_pc(32'h7FFF_FFFC);
        tx_idle_on = 1'b0; rx_idle_on = 1'b0;
        test_random(350);
        tx_idle_on = 1'b1; rx_idle_on = 1'b1;
        write_start_pc(32'($urandom));
        test_random(400);
        write_start_pc(32'h0000_1000);
        test_random(400);
        test_halt();
        wait_drained();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
